### rtl/sm3_pkg.sv
// Package: SM3 constants, types and round helper functions.
`default_nettype none
package sm3_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds    = 64;
  localparam logic [31:0] TLow  = 32'h79cc4519;
  localparam logic [31:0] THigh = 32'h7a879d8a;
  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [7:0]  PadByte = 8'h80;

  localparam logic [31:0] Iv [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  typedef enum logic [2:0] {
    ST_FILL,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       load_word;   // write input word into block buffer
    logic       pad_word;    // write generated padding word
    logic       start;       // load round registers from chaining value
    logic       round;       // run one round
    logic       fold;        // xor round registers into chaining value
    logic       reset_cv;    // restore IV, clear length
    logic       shift_out;   // advance digest word pointer
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       block_full;  // sixteenth word just written
    logic       last_round;
    logic [3:0] fill;
    logic       pad_done;    // length low word written
  } dp_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

### rtl/sm3_if.sv
// Interfaces: input word channel and digest channel.
`default_nettype none
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  bytes_valid;
  logic        is_last;
  modport source (output valid, data_word, bytes_valid, is_last, input ready);
  modport sink (input valid, data_word, bytes_valid, is_last, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface
`default_nettype wire

### rtl/sm3_datapath.sv
// Datapath: block buffer, message expansion window, round registers, chaining value.
`default_nettype none
module sm3_datapath
  import sm3_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  bytes_valid,
  input  wire logic        is_last,
  output dp_stat_t         stat,
  output logic [31:0]      digest_word,
  output logic             digest_last
);

  logic [31:0] blk [16];
  logic [31:0] w [16];       // sliding expansion window, w[0] = W[j]
  logic [31:0] r [8];
  logic [31:0] cv [8];
  logic [3:0]  fill;
  logic [63:0] bit_len;
  logic [5:0]  rnd;
  logic [2:0]  out_idx;
  logic [31:0] t_rot;

  // final-word formatting
  logic [2:0]  nb;
  logic [31:0] keep, last_word, pad_val, wr_val;
  logic [63:0] len_next;
  logic [5:0]  len_add;

  logic [31:0] a12, ss1, ss2, f, g, tt1, tt2, w_new;
  logic        lo;

  // pad_word after a full final word first writes 0x80000000
  logic need_marker;
  // length high word sits at word 14; the low word may only follow it
  logic len_hi;

  always_comb begin
    nb = (bytes_valid > 3'd4) ? 3'd4 : bytes_valid;
    case (nb)
      3'd0: keep = 32'h00000000;
      3'd1: keep = 32'hff000000;
      3'd2: keep = 32'hffff0000;
      3'd3: keep = 32'hffffff00;
      default: keep = 32'hffffffff;
    endcase
    case (nb)
      3'd0: last_word = PadWord;
      3'd1: last_word = (data_word & keep) | 32'h00800000;
      3'd2: last_word = (data_word & keep) | 32'h00008000;
      3'd3: last_word = (data_word & keep) | {24'd0, PadByte};
      default: last_word = data_word;
    endcase
    len_add = is_last ? {nb, 3'b000} : 6'd32;
    len_next = bit_len + {58'd0, len_add};
    if (fill == 4'd14)                pad_val = bit_len[63:32];
    else if (fill == 4'd15 && len_hi) pad_val = bit_len[31:0];
    else                              pad_val = '0;
    wr_val = cmd.pad_word ? pad_val : last_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bit_len <= '0;
      need_marker <= 1'b0;
      len_hi <= 1'b0;
      out_idx <= '0;
      rnd <= '0;
      for (int i = 0; i < 8; i++) cv[i] <= Iv[i];
    end else begin
      if (cmd.load_word) begin
        blk[fill] <= is_last ? last_word : data_word;
        fill <= fill + 4'd1;
        bit_len <= len_next;
        need_marker <= is_last && (nb == 3'd4);
      end else if (cmd.pad_word) begin
        blk[fill] <= need_marker ? PadWord : wr_val;
        need_marker <= 1'b0;
        len_hi <= !need_marker && (fill == 4'd14);
        fill <= fill + 4'd1;
      end
      if (cmd.start) begin
        for (int i = 0; i < 8; i++) r[i] <= cv[i];
        for (int i = 0; i < 16; i++) w[i] <= blk[i];
        rnd <= '0;
        t_rot <= TLow;
      end else if (cmd.round) begin
        r[3] <= r[2]; r[2] <= rotl(r[1], 5'd9); r[1] <= r[0]; r[0] <= tt1;
        r[7] <= r[6]; r[6] <= rotl(r[5], 5'd19); r[5] <= r[4]; r[4] <= p0(tt2);
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= w_new;
        rnd <= rnd + 6'd1;
        t_rot <= (rnd == 6'd15) ? rotl(THigh, 5'd16) : rotl(t_rot, 5'd1);
      end
      if (cmd.fold)
        for (int i = 0; i < 8; i++) cv[i] <= cv[i] ^ r[i];
      // pointer wraps to zero after the eighth word
      if (cmd.shift_out) out_idx <= out_idx + 3'd1;
      if (cmd.reset_cv) begin
        for (int i = 0; i < 8; i++) cv[i] <= Iv[i];
        fill <= '0;
        bit_len <= '0;
      end
    end
  end

  always_comb begin
    lo  = (rnd < 6'd16);
    a12 = rotl(r[0], 5'd12);
    ss1 = rotl(a12 + r[4] + t_rot, 5'd7);
    ss2 = ss1 ^ a12;
    f = lo ? (r[0] ^ r[1] ^ r[2]) : ((r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]));
    g = lo ? (r[4] ^ r[5] ^ r[6]) : ((r[4] & r[5]) | (~r[4] & r[6]));
    tt1 = f + r[3] + ss2 + (w[0] ^ w[4]);
    tt2 = g + r[7] + ss1 + w[0];
    w_new = p1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
  end

  assign stat.block_full = (fill == 4'd15) && (cmd.load_word || cmd.pad_word);
  assign stat.last_round = (rnd == 6'(Rounds - 1));
  assign stat.fill       = fill;
  assign stat.pad_done   = cmd.pad_word && !need_marker && (fill == 4'd15) && len_hi;
  assign digest_word     = cv[out_idx];
  assign digest_last     = (out_idx == 3'd7);

endmodule
`default_nettype wire

### rtl/sm3_ctrl.sv
// Controller: sequences fill, rounds, padding and digest readout.
`default_nettype none
module sm3_ctrl
  import sm3_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire logic     digest_last,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state, state_next;
  logic   finishing, finishing_next;
  // length words are written in the same block that ends padding
  logic   pad_written;
  logic   start_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      finishing <= 1'b0;
    end else begin
      state <= state_next;
      finishing <= finishing_next;
    end
  end

  always_comb begin
    state_next = state;
    finishing_next = finishing;
    case (state)
      ST_FILL: if (in_valid) begin
        if (stat.block_full) state_next = ST_ROUND;
        else if (in_last) state_next = ST_PAD;
        finishing_next = in_last;
      end
      ST_PAD: if (stat.pad_done || stat.block_full) state_next = ST_ROUND;
      ST_ROUND: if (stat.last_round) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!finishing) state_next = ST_FILL;
        else if (stat.fill == 4'd0 && pad_written) state_next = ST_OUT;
        else state_next = ST_PAD;
      end
      ST_OUT: if (out_ready && digest_last) begin
        state_next = ST_FILL;
        finishing_next = 1'b0;
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) pad_written <= 1'b0;
    else if (state == ST_OUT) pad_written <= 1'b0;
    else if (stat.pad_done) pad_written <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) start_pend <= 1'b0;
    else start_pend <= (state != ST_ROUND) && (state_next == ST_ROUND);
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_FILL: begin
        in_ready = 1'b1;
        cmd.load_word = in_valid;
      end
      ST_PAD: cmd.pad_word = 1'b1;
      ST_ROUND: begin
        cmd.start = start_pend;
        cmd.round = !start_pend;
      end
      ST_FOLD: cmd.fold = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.shift_out = out_ready;
        cmd.reset_cv = out_ready && digest_last;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_both: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output open together");
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load_word, cmd.pad_word, cmd.round, cmd.fold}) <= 1)
    else $error("conflicting datapath commands");
  a_fold_after: assert property (@(posedge clk) disable iff (rst)
    cmd.fold |-> $past(state == ST_ROUND))
    else $error("fold without rounds");
`endif

endmodule
`default_nettype wire

### rtl/sm3_hash_engine.sv
// Top level: SM3 hash engine.
// Words are taken one per cycle while a block fills; each full block then
// runs a load step and 64 rounds, one per cycle through a single round
// unit, and is folded into the chaining value before new words are taken.
// After the final word, padding words are written one per cycle and the
// last one or two blocks are compressed; the eight digest words then leave
// one per output transfer.
`default_nettype none
module sm3_hash_engine
  import sm3_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sm3_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_last(in_ch.is_last), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .digest_last(out_ch.digest_last), .stat(stat), .cmd(cmd)
  );

  sm3_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .data_word(in_ch.data_word), .bytes_valid(in_ch.bytes_valid),
    .is_last(in_ch.is_last), .stat(stat),
    .digest_word(out_ch.digest_word), .digest_last(out_ch.digest_last)
  );

endmodule
`default_nettype wire

### verif/sm3_digest_checker.sv
// Checker: watches the word and digest channels, predicts SM3 digests, compares.
`timescale 1ns / 1ps
module sm3_digest_checker
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sm3_in_if           in_ch,
  sm3_out_if          out_ch,
  output int          fail_count,
  output int          pending
);

  logic [31:0] cv [8];
  logic [31:0] blk [16];
  logic [3:0]  fill;
  logic [63:0] bit_len;
  logic [32:0] digest_q [$];
  int          mismatch_count;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm_p0(logic [31:0] x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic logic [31:0] perm_p1(logic [31:0] x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  task automatic compress();
    logic [31:0] w [68];
    logic [31:0] r [8];
    logic [31:0] t, a12, ss1, ss2, f, g, tt1, tt2;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++)
      w[j] = perm_p1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    for (int j = 0; j < 8; j++) r[j] = cv[j];
    for (int j = 0; j < 64; j++) begin
      t = (j < 16) ? TLow : THigh;
      a12 = rol(r[0], 12);
      ss1 = rol(a12 + r[4] + rol(t, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        f = r[0] ^ r[1] ^ r[2];
        g = r[4] ^ r[5] ^ r[6];
      end else begin
        f = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        g = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = f + r[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = g + r[7] + ss1 + w[j];
      r[3] = r[2]; r[2] = rol(r[1], 9); r[1] = r[0]; r[0] = tt1;
      r[7] = r[6]; r[6] = rol(r[5], 19); r[5] = r[4]; r[4] = perm_p0(tt2);
    end
    for (int j = 0; j < 8; j++) cv[j] ^= r[j];
  endtask

  task automatic push_word(logic [31:0] w);
    blk[fill] = w;
    fill = fill + 4'd1;
    if (fill == 4'd0) compress();
  endtask

  task automatic absorb_word(logic [31:0] data, logic [2:0] nb_in, logic last);
    int nb, shift;
    logic [31:0] keep;
    if (!last) begin
      bit_len += 64'd32;
      push_word(data);
      return;
    end
    nb = (nb_in > 3'd4) ? 4 : int'(nb_in);
    bit_len += 64'(nb * 8);
    if (nb == 4) begin
      push_word(data);
      push_word(PadWord);
    end else begin
      shift = 8 * (4 - nb);
      keep = (nb == 0) ? 32'h0 : (32'hffffffff << shift);
      push_word((data & keep) | (32'h80 << (shift - 8)));
    end
    if (fill == 4'd15) push_word(32'h0);
    while (fill != 4'd14) push_word(32'h0);
    push_word(bit_len[63:32]);
    push_word(bit_len[31:0]);
    for (int k = 0; k < 8; k++) digest_q.push_back({k == 7, cv[k]});
    cv = Iv;
    fill = '0;
    bit_len = '0;
  endtask

  assign pending = digest_q.size();

  always @(posedge clk) begin
    logic [32:0] exp_d;
    if (rst) begin
      cv = Iv;
      fill = '0;
      bit_len = '0;
      digest_q.delete();
      fail_count = 0;
      mismatch_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: unexpected digest word %h last %b",
                     out_ch.digest_word, out_ch.digest_last);
        end else begin
          exp_d = digest_q.pop_front();
          if (out_ch.digest_word !== exp_d[31:0] || out_ch.digest_last !== exp_d[32]) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: digest word expected %h last %b, got %h last %b",
                       exp_d[31:0], exp_d[32], out_ch.digest_word, out_ch.digest_last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        absorb_word(in_ch.data_word, in_ch.bytes_valid, in_ch.is_last);
    end
  end

endmodule

### verif/tb_top.sv
// Testbench top: drives message words, stalls the digest side, gives the verdict.
`timescale 1ns / 1ps
module tb_top;
  import sm3_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   word_count;

  sm3_in_if  in_ch ();
  sm3_out_if out_ch ();

  sm3_hash_engine dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  sm3_digest_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  // receiver stalls
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_word(logic [31:0] data, logic [2:0] nb, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_word <= data;
    in_ch.bytes_valid <= nb;
    in_ch.is_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    word_count++;
  endtask

  task automatic release_valid();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // one message of n full words then a final word
  task automatic send_message(int n, logic [2:0] nb, logic [31:0] fill_val, bit rnd);
    for (int i = 0; i < n; i++)
      send_word(rnd ? $urandom() : fill_val, 3'($urandom_range(7)), 1'b0);
    send_word(rnd ? $urandom() : fill_val, nb, 1'b1);
  endtask

  task automatic drain();
    release_valid();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_word = '0;
    in_ch.bytes_valid = '0;
    in_ch.is_last = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    word_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: "abc", empty message, each byte count, block-boundary lengths
    send_word(32'h61626300, 3'd3, 1'b1);
    send_word(32'hffffffff, 3'd0, 1'b1);
    for (int nb = 1; nb <= 7; nb++) send_word(32'hffffffff, 3'(nb), 1'b1);
    send_message(13, 3'd4, 32'h00000000, 1'b0);
    send_message(13, 3'd3, 32'hffffffff, 1'b0);
    drain();

    // random messages across the idle/stall phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      while (word_count < 65 * (phase + 1)) begin
        if ($urandom_range(3) == 0)
          send_message($urandom_range(12, 17), 3'($urandom_range(7)), 32'h0, 1'b1);
        else send_message($urandom_range(0, 6), 3'($urandom_range(7)), 32'h0, 1'b1);
      end
      if (phase == 1) drain();
    end

    release_valid();
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
